[hw/rtl/selection_sorter_defines.svh]
// Assertion macros shared by the selection sorter RTL.
`ifndef SELECTION_SORTER_DEFINES_SVH
`define SELECTION_SORTER_DEFINES_SVH

// Same-cycle implication, checked on clk and masked during reset.
`define SSORT_ASSERT_IMPLY(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// Next-cycle implication, checked on clk and masked during reset.
`define SSORT_ASSERT_NEXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

[hw/rtl/ssort_pkg.sv]
// Shared constants, state codes and control structs for the selection sorter.
package ssort_pkg;

	localparam int DEPTH = 64;
	localparam int WIDTH = 32;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_SCAN      = 7'b0000010,
		ST_DRAIN     = 7'b0000100,
		ST_SWAP_A    = 7'b0001000,
		ST_SWAP_B    = 7'b0010000,
		ST_OUT       = 7'b0100000,
		ST_OUT_DRAIN = 7'b1000000
	} state_t;

	typedef struct packed {
		logic accept;
		logic begin_sort;
		logic scan_rd;
		logic swap_a;
		logic swap_b;
		logic rewind;
		logic out_rd;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic multi;
		logic scan_at_last;
		logic next_pos_last;
	} status_t;

endpackage

[hw/rtl/ssort_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssort_ram #(
	parameter int W = 32,
	parameter int D = 64,
	parameter int A = (D > 1) ? $clog2(D) : 1
) (
	input  logic         clk,
	input  logic         we,
	input  logic [A-1:0] waddr,
	input  logic [W-1:0] wdata,
	input  logic [A-1:0] raddr,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/ssort_dp.sv]
// Datapath: element store, counters, min tracking and result stage.
module ssort_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ssort_pkg::cmd_t                 cmd,
	input  logic signed [ssort_pkg::WIDTH-1:0] value,
	output ssort_pkg::status_t              status,
	output logic                            strobe,
	output logic signed [ssort_pkg::WIDTH-1:0] sorted_value,
	output logic                            last_of_run,
	output logic                            overflowed
);

	logic [ssort_pkg::CW-1:0]    count_q;
	logic [ssort_pkg::CW-1:0]    count_nxt;
	logic                        ovf_q;
	logic                        full;
	logic [ssort_pkg::AW-1:0]    last_idx;
	logic [ssort_pkg::AW-1:0]    pos_q;
	logic [ssort_pkg::AW-1:0]    scan_q;
	logic [ssort_pkg::WIDTH-1:0] best_q;
	logic [ssort_pkg::AW-1:0]    best_idx_q;
	logic [ssort_pkg::WIDTH-1:0] pos_val_q;
	logic                        cmp_s1;
	logic                        first_s1;
	logic [ssort_pkg::AW-1:0]    addr_s1;
	logic                        out_s1;
	logic                        last_s1;
	logic                        we;
	logic [ssort_pkg::AW-1:0]    waddr;
	logic [ssort_pkg::WIDTH-1:0] wdata;
	logic [ssort_pkg::WIDTH-1:0] rdata;

	assign full      = (count_q == ssort_pkg::CW'(ssort_pkg::DEPTH));
	assign count_nxt = full ? count_q : count_q + ssort_pkg::CW'(1);
	assign last_idx  = ssort_pkg::AW'(count_q - ssort_pkg::CW'(1));

	assign status.multi         = (count_nxt > ssort_pkg::CW'(1));
	assign status.scan_at_last  = (scan_q == last_idx);
	assign status.next_pos_last = ((pos_q + ssort_pkg::AW'(1)) == last_idx);

	// write port: load, then the two halves of a swap
	always_comb begin
		we    = 1'b0;
		waddr = count_q[ssort_pkg::AW-1:0];
		wdata = value;
		if (cmd.accept) begin
			we = !full;
		end else if (cmd.swap_a) begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = best_q;
		end else if (cmd.swap_b) begin
			we    = 1'b1;
			waddr = best_idx_q;
			wdata = pos_val_q;
		end
	end

	ssort_ram #(
		.W(ssort_pkg::WIDTH),
		.D(ssort_pkg::DEPTH),
		.A(ssort_pkg::AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(scan_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			cmp_s1  <= 1'b0;
			out_s1  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.accept) begin
				count_q <= count_nxt;
				if (full) begin
					ovf_q <= 1'b1;
				end
			end
			cmp_s1 <= cmd.scan_rd;
			out_s1 <= cmd.out_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_sort) begin
			pos_q  <= '0;
			scan_q <= '0;
		end else if (cmd.scan_rd || cmd.out_rd) begin
			scan_q <= scan_q + ssort_pkg::AW'(1);
		end else if (cmd.swap_b) begin
			pos_q  <= pos_q + ssort_pkg::AW'(1);
			scan_q <= cmd.rewind ? '0 : pos_q + ssort_pkg::AW'(1);
		end
		first_s1 <= (scan_q == pos_q);
		addr_s1  <= scan_q;
		last_s1  <= (scan_q == last_idx);
		// min search: first word of a pass seeds it, ties keep the earlier index
		if (cmp_s1) begin
			if (first_s1) begin
				best_q     <= rdata;
				best_idx_q <= addr_s1;
				pos_val_q  <= rdata;
			end else if ($signed(rdata) < $signed(best_q)) begin
				best_q     <= rdata;
				best_idx_q <= addr_s1;
			end
		end
	end

	assign strobe       = out_s1;
	assign sorted_value = $signed(rdata);
	assign last_of_run  = last_s1;
	assign overflowed   = ovf_q;

endmodule

[hw/rtl/ssort_ctrl.sv]
// Controller: load, scan/swap passes and output sequencing.
module ssort_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                is_last,
	input  ssort_pkg::status_t  status,
	output ssort_pkg::cmd_t     cmd,
	output logic                busy
);

	ssort_pkg::state_t state_q;
	ssort_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ssort_pkg::ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (is_last) begin
						cmd.begin_sort = 1'b1;
						state_nxt = status.multi ? ssort_pkg::ST_SCAN : ssort_pkg::ST_OUT;
					end
				end
			end
			ssort_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_at_last) begin
					state_nxt = ssort_pkg::ST_DRAIN;
				end
			end
			ssort_pkg::ST_DRAIN: begin
				state_nxt = ssort_pkg::ST_SWAP_A;
			end
			ssort_pkg::ST_SWAP_A: begin
				cmd.swap_a = 1'b1;
				state_nxt  = ssort_pkg::ST_SWAP_B;
			end
			ssort_pkg::ST_SWAP_B: begin
				cmd.swap_b = 1'b1;
				if (status.next_pos_last) begin
					cmd.rewind = 1'b1;
					state_nxt  = ssort_pkg::ST_OUT;
				end else begin
					state_nxt = ssort_pkg::ST_SCAN;
				end
			end
			ssort_pkg::ST_OUT: begin
				cmd.out_rd = 1'b1;
				if (status.scan_at_last) begin
					state_nxt = ssort_pkg::ST_OUT_DRAIN;
				end
			end
			ssort_pkg::ST_OUT_DRAIN: begin
				cmd.clear = 1'b1;
				state_nxt = ssort_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ssort_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssort_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ssort_pkg::ST_IDLE);

endmodule

[hw/rtl/selection_sorter.sv]
// Top level of the selection sorter: controller, datapath and checks.
//
// Usage: present a word on value/is_last with start high; it is taken at a
// rising edge where busy is low. Words are stored in a DEPTH-entry RAM; words
// that arrive when the store is full are dropped and the set is flagged.
// The word with is_last set closes the set: busy rises on the next cycle and
// the block sorts the n stored words ascending (signed) by selection sort.
// Each pass over the remaining m words reads one word per cycle through a
// single comparator, then drains the read pipeline and swaps the minimum
// into place, one half at a time through the single RAM write port.
// Results then stream out on consecutive cycles, one per stored word, each
// marked by strobe for exactly one cycle, last_of_run on the final one and
// overflowed on every one if the set lost words. The receiver cannot stall:
// results must be taken as they come. busy drops in the cycle after the
// final result; the next set may start then. Reset (arst_n low) empties the
// store count and overflow flag and returns the block to idle; RAM contents
// are not cleared and need not be.
`include "selection_sorter_defines.svh"

module selection_sorter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [ssort_pkg::WIDTH-1:0] value,
	input  logic                               is_last,
	output logic                               strobe,
	output logic signed [ssort_pkg::WIDTH-1:0] sorted_value,
	output logic                               last_of_run,
	output logic                               overflowed
);

	ssort_pkg::cmd_t    cmd;
	ssort_pkg::status_t status;

	ssort_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.is_last(is_last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ssort_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.status      (status),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.last_of_run (last_of_run),
		.overflowed  (overflowed)
	);

	// results only come out while a set is being sorted or drained
	`SSORT_ASSERT_IMPLY(a_strobe_busy, strobe, busy, "result strobe while idle")
	// a closing word always starts a sort
	`SSORT_ASSERT_NEXT(a_close_busy, start && !busy && is_last, busy, "close did not start sort")
	// results of one set are contiguous
	`SSORT_ASSERT_NEXT(a_stream, strobe && !last_of_run, strobe, "gap in result stream")
	// nothing follows the final result
	`SSORT_ASSERT_NEXT(a_end, strobe && last_of_run, !strobe, "result after final word")

endmodule

[bench/selection_sorter_tb.sv]
// Self-checking bench for the selection sorter: directed and random sets, checked per word.

typedef struct packed {
	logic signed [ssort_pkg::WIDTH-1:0] value;
	logic                               last;
	logic                               ovf;
} sorted_word_t;

// Predicts every sorted word of a set and checks the words the block emits.
class sort_scoreboard;
	logic signed [ssort_pkg::WIDTH-1:0] held [ssort_pkg::DEPTH];
	int           held_count;
	bit           dropped;
	sorted_word_t expected_sorted [$];
	int           mismatches;

	function new();
		held_count = 0;
		dropped    = 0;
		mismatches = 0;
	endfunction

	// Selection sort on the held words: strict less-than, earliest wins on ties.
	function void sort_held();
		int                                 best;
		logic signed [ssort_pkg::WIDTH-1:0] tmp;
		for (int pos = 0; pos < held_count; pos++) begin
			best = pos;
			for (int scan = pos + 1; scan < held_count; scan++)
				if (held[scan] < held[best])
					best = scan;
			tmp        = held[best];
			held[best] = held[pos];
			held[pos]  = tmp;
		end
	endfunction

	// Called for each word taken by the block.
	function void take_word(logic signed [ssort_pkg::WIDTH-1:0] v, logic last);
		sorted_word_t w;
		if (held_count < ssort_pkg::DEPTH) begin
			held[held_count] = v;
			held_count++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		sort_held();
		for (int k = 0; k < held_count; k++) begin
			w.value = held[k];
			w.last  = (k == held_count - 1);
			w.ovf   = dropped;
			expected_sorted.push_back(w);
		end
		held_count = 0;
		dropped    = 1'b0;
	endfunction

	// Called for each strobed result.
	function void check_result(logic signed [ssort_pkg::WIDTH-1:0] v, logic last, logic ovf);
		sorted_word_t w;
		if (expected_sorted.size() == 0) begin
			$display("%0t: unexpected result value=%0d last=%0b ovf=%0b", $time, v, last, ovf);
			mismatches++;
			return;
		end
		w = expected_sorted.pop_front();
		if (v !== w.value) begin
			$display("%0t: sorted_value expected %0d actual %0d", $time, w.value, v);
			mismatches++;
		end
		if (last !== w.last) begin
			$display("%0t: last_of_run expected %0b actual %0b", $time, w.last, last);
			mismatches++;
		end
		if (ovf !== w.ovf) begin
			$display("%0t: overflowed expected %0b actual %0b", $time, w.ovf, ovf);
			mismatches++;
		end
	endfunction
endclass

module selection_sorter_tb;

	localparam int WATCHDOG_LIMIT = 20000; // a full 64-word sort takes no words and emits no results while it runs
	localparam int RANDOM_WORDS   = 236;
	localparam int MAX_GAP        = 17;

	logic                               clk     = 1'b0;
	logic                               arst_n  = 1'b0;
	logic                               start   = 1'b0;
	logic signed [ssort_pkg::WIDTH-1:0] value   = '0;
	logic                               is_last = 1'b0;
	logic                               busy;
	logic                               strobe;
	logic signed [ssort_pkg::WIDTH-1:0] sorted_value;
	logic                               last_of_run;
	logic                               overflowed;

	sort_scoreboard sb = new();
	int             idle_cycles = 0;

	selection_sorter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.is_last     (is_last),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.last_of_run (last_of_run),
		.overflowed  (overflowed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Results cannot be held off: every strobed cycle is a result word.
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(sorted_value, last_of_run, overflowed);
	end

	// Watchdog: cycles with neither a word taken nor a result emitted.
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: watchdog expired", $time);
		$display("status: fail");
		$finish;
	end

	// Drive one word after an idle gap, hold it until the block takes it.
	// start stays high on return so a zero gap next time keeps it asserted
	// without a low/high pair in the same step.
	task automatic send_word(input logic signed [ssort_pkg::WIDTH-1:0] v, input logic last,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		value   <= v;
		is_last <= last;
		do @(posedge clk); while (busy !== 1'b0);
		sb.take_word(v, last);
	endtask

	// Mix of extremes, a narrow band around zero (lots of ties) and full-range noise.
	function automatic logic signed [ssort_pkg::WIDTH-1:0] pick_value();
		int r;
		r = $urandom_range(0, 6);
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3: return r - 3;
			default: return $urandom;
		endcase
	endfunction

	// burst: back-to-back words with no idle cycles at all
	task automatic send_set(input int size, input bit burst);
		for (int i = 0; i < size; i++)
			send_word(pick_value(), i == size - 1, burst ? 0 : $urandom_range(0, MAX_GAP));
	endtask

	initial begin
		int random_sent;
		int set_no;
		int size;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single word set holding the most negative value
		send_word(32'sh8000_0000, 1'b1, $urandom_range(0, MAX_GAP));

		// extremes, sign boundary and alternating bit patterns
		send_word(32'sh7FFF_FFFF, 1'b0, $urandom_range(0, MAX_GAP));
		send_word(32'sh8000_0000, 1'b0, $urandom_range(0, MAX_GAP));
		send_word(32'sh0000_0000, 1'b0, 0);
		send_word(-32'sd1,        1'b0, 0);
		send_word(32'sh0000_0001, 1'b0, $urandom_range(0, MAX_GAP));
		send_word(32'sh5555_5555, 1'b0, 0);
		send_word(32'shAAAA_AAAA, 1'b1, $urandom_range(0, MAX_GAP));

		// equal values
		send_word(32'sd5,  1'b0, 0);
		send_word(-32'sd5, 1'b0, 0);
		send_word(32'sd5,  1'b0, 0);
		send_word(32'sd5,  1'b0, 0);
		send_word(-32'sd5, 1'b1, 0);

		// already ascending, then strictly descending
		for (int i = -2; i <= 2; i++)
			send_word(i, i == 2, $urandom_range(0, 3));
		for (int i = 2; i >= -2; i--)
			send_word(i, i == -2, $urandom_range(0, 3));

		// Random sets. Most are short to keep sort time down; one fills the
		// store exactly and one overruns it so the closing word is dropped too.
		random_sent = 0;
		set_no      = 0;
		while (random_sent < RANDOM_WORDS) begin
			if (set_no == 3)
				size = ssort_pkg::DEPTH;
			else if (set_no == 8)
				size = ssort_pkg::DEPTH + $urandom_range(1, 4);
			else if ($urandom_range(0, 9) == 0)
				size = $urandom_range(9, 40);
			else
				size = $urandom_range(1, 8);
			send_set(size, $urandom_range(0, 3) == 0);
			random_sent += size;
			set_no++;
		end
		start <= 1'b0;

		// drain; the watchdog catches a block that never finishes
		while (sb.expected_sorted.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
